>>> rtl/core/cfir_pkg.sv
// Shared constants, payload types and control structs of the complex FIR filter core.
package cfir_pkg;

   localparam int MAX_TAPS       = 1024;
   localparam int SAMPLE_BITS    = 16;
   localparam int ADDR_W         = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int COUNT_W        = $clog2(MAX_TAPS + 1);
   localparam int TAP_INDEX_W    = 10;
   localparam int NUM_TAPS_W     = 11;
   localparam int NUM_TAPS_RESET = 1;
   localparam int ACC_W          = 48;
   localparam int PROD_W         = 2 * SAMPLE_BITS;
   localparam int WORD_W         = 2 * SAMPLE_BITS;

   typedef enum logic [1:0] {
      OP_LOAD_TAP = 2'd0,
      OP_FILTER   = 2'd1,
      OP_CLEAR    = 2'd2
   } opcode_type;

   typedef struct packed {
      opcode_type                     opcode;
      logic [TAP_INDEX_W-1:0]         tap_index;
      logic signed [SAMPLE_BITS-1:0]  value_i;
      logic signed [SAMPLE_BITS-1:0]  value_q;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] out_i;
      logic signed [ACC_W-1:0] out_q;
   } rsp_type;

   // one MAC step issued by the sequencer
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic zero;
   } mac_ctrl_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

endpackage

>>> rtl/core/cfir_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cfir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cfir_mac.sv
// Complex multiply-accumulate pipeline: align with RAM data, multiply, accumulate.
module cfir_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  cfir_pkg::mac_ctrl_type        ctrl,
   input  logic [cfir_pkg::WORD_W-1:0]   tap_word,
   input  logic [cfir_pkg::WORD_W-1:0]   hist_word,
   output cfir_pkg::rsp_type             acc,
   output logic                          done
);
   import cfir_pkg::*;

   mac_ctrl_type ctrl1_ff, ctrl2_ff;

   logic signed [SAMPLE_BITS-1:0] ci, cq, xi, xq;
   logic signed [PROD_W-1:0]      p_ii_in, p_qq_in, p_iq_in, p_qi_in;
   logic signed [PROD_W-1:0]      p_ii_ff, p_qq_ff, p_iq_ff, p_qi_ff;
   logic signed [ACC_W-1:0]       base_i, base_q, acc_i_in, acc_q_in;
   logic signed [ACC_W-1:0]       acc_i_ff, acc_q_ff;
   logic                          done_ff;

   // drop history terms that lie before the stream start
   always_comb begin
      ci = $signed(tap_word[SAMPLE_BITS-1:0]);
      cq = $signed(tap_word[WORD_W-1:SAMPLE_BITS]);
      xi = ctrl1_ff.zero ? '0 : $signed(hist_word[SAMPLE_BITS-1:0]);
      xq = ctrl1_ff.zero ? '0 : $signed(hist_word[WORD_W-1:SAMPLE_BITS]);
      p_ii_in = ci * xi;
      p_qq_in = cq * xq;
      p_iq_in = ci * xq;
      p_qi_in = cq * xi;
   end

   always_comb begin
      base_i   = ctrl2_ff.first ? '0 : acc_i_ff;
      base_q   = ctrl2_ff.first ? '0 : acc_q_ff;
      acc_i_in = base_i + ACC_W'(p_ii_ff) - ACC_W'(p_qq_ff);
      acc_q_in = base_q + ACC_W'(p_iq_ff) + ACC_W'(p_qi_ff);
   end

   always_ff @(posedge clock) begin
      p_ii_ff <= p_ii_in;
      p_qq_ff <= p_qq_in;
      p_iq_ff <= p_iq_in;
      p_qi_ff <= p_qi_in;
      if (ctrl2_ff.valid) begin
         acc_i_ff <= acc_i_in;
         acc_q_ff <= acc_q_in;
      end
      if (reset) begin
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         ctrl1_ff <= ctrl;
         ctrl2_ff <= ctrl1_ff;
         done_ff  <= ctrl2_ff.valid && ctrl2_ff.last;
      end
   end

   assign acc.out_i = acc_i_ff;
   assign acc.out_q = acc_q_ff;
   assign done      = done_ff;

endmodule

>>> rtl/core/cfir_seq.sv
// Request sequencer: tap loads, history writes, tap sweep and result register.
module cfir_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cfir_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cfir_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [cfir_pkg::NUM_TAPS_W-1:0] csr_wdata,
   output cfir_pkg::ram_wr_type            tap_wr,
   output cfir_pkg::ram_wr_type            hist_wr,
   output logic [cfir_pkg::ADDR_W-1:0]     tap_rd_addr,
   output logic [cfir_pkg::ADDR_W-1:0]     hist_rd_addr,
   output cfir_pkg::mac_ctrl_type          mac_ctrl,
   input  cfir_pkg::rsp_type               mac_acc,
   input  logic                            mac_done
);
   import cfir_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       ptr_ff, ptr_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   logic [COUNT_W-1:0]      fill_ff, fill_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic [COUNT_W-1:0]      last_ff, last_in;
   logic                    none_ff, none_in;
   logic [NUM_TAPS_W-1:0]   num_taps_ff, num_taps_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]      ntap;

   // clip the tap count to the store depth
   assign ntap = (32'(num_taps_ff) > MAX_TAPS) ? COUNT_W'(MAX_TAPS) : COUNT_W'(num_taps_ff);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      none_in      = none_ff;
      num_taps_in  = num_taps_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      tap_wr.en    = 1'b0;
      tap_wr.addr  = ADDR_W'(req_data.tap_index);
      tap_wr.data  = {req_data.value_q, req_data.value_i};
      hist_wr.en   = 1'b0;
      hist_wr.addr = ptr_ff;
      hist_wr.data = {req_data.value_q, req_data.value_i};

      mac_ctrl.valid = 1'b0;
      mac_ctrl.first = (cnt_ff == '0);
      mac_ctrl.last  = (cnt_ff == last_ff);
      mac_ctrl.zero  = (cnt_ff >= fill_ff) || none_ff;

      if (csr_we) begin
         num_taps_in = csr_wdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode)
                  OP_LOAD_TAP: begin
                     tap_wr.en = (32'(req_data.tap_index) < MAX_TAPS);
                  end
                  OP_FILTER: begin
                     hist_wr.en = 1'b1;
                     pos_in     = ptr_ff;
                     ptr_in     = (ptr_ff == ADDR_W'(MAX_TAPS - 1)) ? '0
                                                                    : ptr_ff + ADDR_W'(1);
                     fill_in    = (fill_ff == COUNT_W'(MAX_TAPS)) ? fill_ff
                                                                  : fill_ff + COUNT_W'(1);
                     cnt_in     = '0;
                     none_in    = (ntap == '0);
                     last_in    = (ntap == '0) ? '0 : ntap - COUNT_W'(1);
                     state_in   = S_ISSUE;
                  end
                  OP_CLEAR: begin
                     ptr_in  = '0;
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ISSUE: begin
            mac_ctrl.valid = 1'b1;
            cnt_in = cnt_ff + COUNT_W'(1);
            pos_in = (pos_ff == '0) ? ADDR_W'(MAX_TAPS - 1) : pos_ff - ADDR_W'(1);
            if (cnt_ff == last_ff) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mac_acc;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      none_ff     <= none_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         num_taps_ff  <= NUM_TAPS_W'(NUM_TAPS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         num_taps_ff  <= num_taps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign tap_rd_addr  = cnt_ff[ADDR_W-1:0];
   assign hist_rd_addr = pos_ff;

endmodule

>>> rtl/core/complex_fir_filter_core.sv
// Top level of the complex FIR filter core: sequencer, tap and history RAMs, MAC.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_data  (opcode, tap_index, value_i/q)
//  rsp_      out        rsp_valid/rsp_stall  rsp_data  (out_i, out_q)
//  csr_      in         csr_we               csr_wdata (num_taps)
//
// A filter request sweeps max(n,1) taps, n = num_taps clipped to MAX_TAPS: the
// single complex MAC consumes one tap per cycle from the read ports of the two RAMs.
// Load-tap, clear and unused requests are taken in the idle state and do not stall the input.
// Reset is synchronous; it clears the control state and needs no clearing pass, since
// a fill count marks which history slots have been written since the last clear.
// A result waiting under rsp_stall does not block the next request; a finished sum
// holds in the MAC until the result register is free.
module complex_fir_filter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cfir_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cfir_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [cfir_pkg::NUM_TAPS_W-1:0] csr_wdata
);
   import cfir_pkg::*;

   ram_wr_type        tap_wr, hist_wr;
   logic [ADDR_W-1:0] tap_rd_addr, hist_rd_addr;
   logic [WORD_W-1:0] tap_word, hist_word;
   mac_ctrl_type      mac_ctrl;
   rsp_type           mac_acc;
   logic              mac_done;

   // sequence requests, sweep taps and hold the result register
   cfir_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .tap_wr       (tap_wr),
      .hist_wr      (hist_wr),
      .tap_rd_addr  (tap_rd_addr),
      .hist_rd_addr (hist_rd_addr),
      .mac_ctrl     (mac_ctrl),
      .mac_acc      (mac_acc),
      .mac_done     (mac_done)
   );

   // complex coefficients, {q, i}
   cfir_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_wr.en),
      .wr_addr (tap_wr.addr),
      .wr_data (tap_wr.data),
      .rd_addr (tap_rd_addr),
      .rd_data (tap_word)
   );

   // circular sample history, {q, i}; the newest slot is written in the cycle before it is read
   cfir_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr.en),
      .wr_addr (hist_wr.addr),
      .wr_data (hist_wr.data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_word)
   );

   // multiply and accumulate one tap per cycle
   cfir_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .tap_word  (tap_word),
      .hist_word (hist_word),
      .acc       (mac_acc),
      .done      (mac_done)
   );

endmodule

>>> rtl/core/cfir_checker.sv
// Port-level assertions of the complex FIR filter core, bound to the top level.
module cfir_core_props (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input cfir_pkg::req_type     req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input cfir_pkg::rsp_type     rsp_data
);
   import cfir_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.opcode == OP_FILTER |=> req_stall)
      else $error("filter request did not start a sweep");

   a_short_free: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.opcode != OP_FILTER |=> !req_stall)
      else $error("non-filter request blocked the input");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a sweep");

endmodule

bind complex_fir_filter_core cfir_core_props u_checker (.*);
